### hw/rtl/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package wsd_pkg;

  localparam int unsigned CapW     = 17;
  localparam int unsigned CountW   = 16;
  localparam int unsigned LenW     = 64;
  localparam int unsigned KeyW     = 32;
  localparam int unsigned PaddrW   = 3;
  localparam int unsigned PdataW   = 32;

  localparam logic [CapW-1:0] CapReset = 17'd4096;

  localparam logic [3:0] OpText   = 4'h1;
  localparam logic [3:0] OpBinary = 4'h2;
  localparam logic [3:0] OpClose  = 4'h8;
  localparam logic [3:0] OpPing   = 4'h9;
  localparam logic [3:0] OpPong   = 4'hA;

  localparam logic [6:0] LenExt16 = 7'd126;
  localparam logic [6:0] LenExt64 = 7'd127;

  localparam logic [3:0] Ext16Bytes = 4'd2;
  localparam logic [3:0] Ext64Bytes = 4'd8;
  localparam logic [3:0] MaskBytes  = 4'd4;

  typedef enum logic [2:0] {
    KIND_UNKNOWN = 3'd0,
    KIND_TEXT    = 3'd1,
    KIND_BINARY  = 3'd2,
    KIND_CLOSE   = 3'd3,
    KIND_PING    = 3'd4,
    KIND_PONG    = 3'd5
  } frame_kind_e;

  typedef struct packed {
    logic              has_byte;
    logic [7:0]        data_byte;
    logic              frame_end;
    frame_kind_e       frame_kind;
    logic [CountW-1:0] kept_count;
    logic              send_pong;
    logic              link_closed;
  } wsd_result_t;

  function automatic frame_kind_e kind_of(input logic [3:0] op);
    frame_kind_e k;
    case (op)
      OpText:   k = KIND_TEXT;
      OpBinary: k = KIND_BINARY;
      OpClose:  k = KIND_CLOSE;
      OpPing:   k = KIND_PING;
      OpPong:   k = KIND_PONG;
      default:  k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/wsd_apb_regs.sv
// APB register file: holds the buffer capacity and derives the keep limit.
// Depends on wsd_pkg.
`default_nettype none

module wsd_apb_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [wsd_pkg::PaddrW-1:0] paddr,
  input  wire logic [wsd_pkg::PdataW-1:0] pwdata,
  output logic      [wsd_pkg::PdataW-1:0] prdata,
  output logic                            pready,
  output logic      [wsd_pkg::CountW-1:0] keep_lim_o
);
  import wsd_pkg::*;

  logic [CapW-1:0] cap_q;
  logic            wr_en;
  logic            sel_cap;

  assign pready  = 1'b1;
  assign sel_cap = (paddr[PaddrW-1] == 1'b0);
  assign wr_en   = psel && penable && pwrite && pready && sel_cap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (wr_en) begin
      cap_q <= pwdata[CapW-1:0];
    end
  end

  assign prdata = sel_cap ? {{(PdataW-CapW){1'b0}}, cap_q} : '0;

  // saturate at the largest count; capacity zero keeps nothing
  always_comb begin
    if (cap_q[CapW-1]) begin
      keep_lim_o = '1;
    end else if (cap_q[CountW-1:0] == '0) begin
      keep_lim_o = '0;
    end else begin
      keep_lim_o = cap_q[CountW-1:0] - CountW'(1);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/wsd_parser.sv
// Frame parser: header, extended length and mask key state machine, payload unmasking.
// Depends on wsd_pkg; one byte is consumed per step.
`default_nettype none

module wsd_parser (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       step_i,
  input  wire logic [7:0]                 rx_byte_i,
  input  wire logic [wsd_pkg::CountW-1:0] keep_lim_i,
  output logic                            res_valid_o,
  output wsd_pkg::wsd_result_t            res_o
);
  import wsd_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_MASK = 3'd3,
    PH_DATA = 3'd4
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [3:0]        opcode_q, opcode_d;
  logic              mask_q, mask_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [KeyW-1:0]   key_q, key_d;
  logic [LenW-1:0]   rem_q, rem_d;
  logic [CountW-1:0] pos_q, pos_d;
  logic [1:0]        lo_q, lo_d;
  logic              closed_q, closed_d;

  logic              go_after, go_start, fin, fin_has;
  logic [7:0]        fin_data, key_byte, data_b;
  logic              keep;
  logic [3:0]        cnt_inc;
  logic [CountW-1:0] kept;

  always_comb begin
    case (lo_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  assign data_b  = rx_byte_i ^ key_byte;
  assign keep    = (pos_q < keep_lim_i);
  assign cnt_inc = cnt_q + 4'd1;

  always_comb begin
    phase_d     = phase_q;
    opcode_d    = opcode_q;
    mask_d      = mask_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    key_d       = key_q;
    rem_d       = rem_q;
    pos_d       = pos_q;
    lo_d        = lo_q;
    closed_d    = closed_q;
    go_after    = 1'b0;
    go_start    = 1'b0;
    fin         = 1'b0;
    fin_has     = 1'b0;
    fin_data    = '0;
    kept        = '0;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (step_i && !closed_q) begin
      case (phase_q)
        PH_HDR0: begin
          opcode_d = rx_byte_i[3:0];
          phase_d  = PH_HDR1;
        end
        PH_HDR1: begin
          mask_d = rx_byte_i[7];
          key_d  = '0;
          len_d  = '0;
          if (rx_byte_i[6:0] == LenExt16) begin
            cnt_d   = Ext16Bytes;
            phase_d = PH_EXT;
          end else if (rx_byte_i[6:0] == LenExt64) begin
            cnt_d   = Ext64Bytes;
            phase_d = PH_EXT;
          end else begin
            len_d    = LenW'(rx_byte_i[6:0]);
            go_after = 1'b1;
          end
        end
        PH_EXT: begin
          len_d = {len_q[LenW-9:0], rx_byte_i};
          if (cnt_q != 4'd0) begin
            cnt_d = cnt_q - 4'd1;
          end
          if (cnt_d == 4'd0) begin
            go_after = 1'b1;
          end
        end
        PH_MASK: begin
          key_d = {key_q[KeyW-9:0], rx_byte_i};
          cnt_d = cnt_inc;
          if (cnt_inc >= MaskBytes) begin
            cnt_d    = 4'd0;
            go_start = 1'b1;
          end
        end
        PH_DATA: begin
          lo_d  = lo_q + 2'd1;
          rem_d = rem_q - LenW'(1);
          if (pos_q != '1) begin
            pos_d = pos_q + CountW'(1);
          end
          if (rem_q == LenW'(1)) begin
            fin      = 1'b1;
            fin_has  = keep;
            fin_data = keep ? data_b : 8'd0;
          end else if (keep) begin
            res_valid_o     = 1'b1;
            res_o.has_byte  = 1'b1;
            res_o.data_byte = data_b;
          end
        end
        default: begin
          phase_d = PH_HDR0;
        end
      endcase

      if (go_after) begin
        if (mask_d) begin
          cnt_d   = 4'd0;
          phase_d = PH_MASK;
        end else begin
          go_start = 1'b1;
        end
      end

      if (go_start) begin
        pos_d = '0;
        lo_d  = 2'd0;
        rem_d = len_d;
        if (len_d == '0) begin
          fin = 1'b1;
        end else begin
          phase_d = PH_DATA;
        end
      end

      if (fin) begin
        if ((len_d[LenW-1:CountW] == '0) && (len_d[CountW-1:0] < keep_lim_i)) begin
          kept = len_d[CountW-1:0];
        end else begin
          kept = keep_lim_i;
        end
        if (opcode_q == OpClose) begin
          closed_d = 1'b1;
        end
        phase_d          = PH_HDR0;
        res_valid_o      = 1'b1;
        res_o.has_byte   = fin_has;
        res_o.data_byte  = fin_data;
        res_o.frame_end  = 1'b1;
        res_o.frame_kind = kind_of(opcode_q);
        res_o.kept_count = kept;
        res_o.send_pong  = (opcode_q == OpPing);
      end
    end
    res_o.link_closed = closed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      opcode_q <= '0;
      mask_q   <= 1'b0;
      cnt_q    <= '0;
      len_q    <= '0;
      key_q    <= '0;
      rem_q    <= '0;
      pos_q    <= '0;
      lo_q     <= '0;
      closed_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      mask_q   <= mask_d;
      cnt_q    <= cnt_d;
      len_q    <= len_d;
      key_q    <= key_d;
      rem_q    <= rem_d;
      pos_q    <= pos_d;
      lo_q     <= lo_d;
      closed_q <= closed_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/websocket_frame_deframer_unit.sv
// Top level of the WebSocket frame deframer: input register, parser, result register.
// Depends on wsd_pkg, wsd_apb_regs and wsd_parser.
//
// Takes one received stream byte per clock cycle while the output side keeps up and
// gives at most one result per byte. A byte is registered on request and parsed once
// the output register is empty or not stalled; its result is captured in the output
// register as it is parsed. A stalled result holds the input register, which then
// stalls the sender. Header bytes and dropped payload bytes give no result, but the
// last byte of a frame gives its frame-end result; after a close frame no byte gives
// a result. The keep limit is buffer_capacity minus one (zero for capacity zero),
// capped at 65535. Write the capacity over APB only while no frame is in flight.
`default_nettype none

module websocket_frame_deframer_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [wsd_pkg::PaddrW-1:0] paddr,
  input  wire logic [wsd_pkg::PdataW-1:0] pwdata,
  output logic      [wsd_pkg::PdataW-1:0] prdata,
  output logic                            pready,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [7:0]                 rx_byte_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic                            has_byte_o,
  output logic      [7:0]                 data_byte_o,
  output logic                            frame_end_o,
  output logic      [2:0]                 frame_kind_o,
  output logic      [wsd_pkg::CountW-1:0] kept_count_o,
  output logic                            send_pong_o,
  output logic                            link_closed_o
);
  import wsd_pkg::*;

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              out_valid_q;
  wsd_result_t       out_res_q;
  logic              advance;
  logic              step;
  logic              res_valid;
  wsd_result_t       res;
  logic [CountW-1:0] keep_lim;

  wsd_apb_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .keep_lim_o (keep_lim)
  );

  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  wsd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .rx_byte_i   (in_byte_q),
    .keep_lim_i  (keep_lim),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= rx_byte_i;
    end
    if (advance && res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign has_byte_o    = out_res_q.has_byte;
  assign data_byte_o   = out_res_q.data_byte;
  assign frame_end_o   = out_res_q.frame_end;
  assign frame_kind_o  = out_res_q.frame_kind;
  assign kept_count_o  = out_res_q.kept_count;
  assign send_pong_o   = out_res_q.send_pong;
  assign link_closed_o = out_res_q.link_closed;

  a_mid_frame_has_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_end_o |-> has_byte_o && frame_kind_o == KIND_UNKNOWN
      && kept_count_o == '0 && !send_pong_o)
    else $error("mid-frame result without payload byte or with end fields");

  a_no_byte_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_byte_o |-> data_byte_o == 8'd0)
    else $error("data byte set without payload byte");

  a_pong_on_ping: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && send_pong_o |-> frame_end_o && frame_kind_o == KIND_PING)
    else $error("pong request outside a ping frame end");

  a_close_latches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o && frame_kind_o == KIND_CLOSE |-> link_closed_o)
    else $error("close frame end without closed link");

  a_in_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_byte_q))
    else $error("stalled input stage lost its byte");

endmodule

`default_nettype wire
